FILE: sv/interval_speaker_attribution_assert.svh
// ----------------------------------------------------------------------------
// interval speaker attribution assertion macros
// shared property forms for the attribution block and its turn scanner
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SPEAKER_ATTRIBUTION_ASSERT_SVH
`define INTERVAL_SPEAKER_ATTRIBUTION_ASSERT_SVH

// same-cycle implication
`define ISA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("isa assertion failed");

// next-cycle implication
`define ISA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("isa assertion failed");

`endif

FILE: sv/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// types and constants shared by the speaker attribution block
// ----------------------------------------------------------------------------
package isa_pkg;

	localparam int TIME_W  = 32;
	localparam int RAW_W   = 6;
	localparam int RAW_IDS = 64;
	localparam int GAP_W   = 16;
	localparam int SPK_W   = 7;
	localparam int DIFF_W  = TIME_W + 1;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_ATTR  = 2'd2;

	localparam logic [SPK_W-1:0] UNKNOWN_CODE = 7'h7F;
	localparam logic [GAP_W-1:0] GAP_RESET    = 16'd1000;

	typedef struct packed {
		logic [TIME_W-1:0] ts;
		logic [TIME_W-1:0] te;
		logic [RAW_W-1:0]  owner;
	} turn_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
	} scan_ctl_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [RAW_W-1:0] raw;
	} scan_res_t;

endpackage

FILE: sv/interval_speaker_attribution.sv
// ----------------------------------------------------------------------------
// interval_speaker_attribution
// attributes word intervals to speaker turns and tracks the current line
// ----------------------------------------------------------------------------
// clear and load requests leave busy low and give no strobe
// an attribute request holds busy while the loaded turns are read, one turn
// from the turn memory each cycle, then for a map read, update and line step
// the result strobe comes in the first cycle with busy low; it cannot be held off
// reset clears the turn count, speaker map, line state and sets the gap limit
// to 1000 ms; the turn and map memories are not cleared
`include "interval_speaker_attribution_assert.svh"

module interval_speaker_attribution
	import isa_pkg::*;
#(
	parameter int MAX_TURNS    = 256,
	parameter int MAX_SPEAKERS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic [TIME_W-1:0]       time_start,
	input  logic [TIME_W-1:0]       time_end,
	input  logic [RAW_W-1:0]        raw_speaker,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [GAP_W-1:0]        cfg_data,
	output logic                    done,
	output logic signed [SPK_W-1:0] speaker,
	output logic                    new_line,
	output logic [TIME_W-1:0]       line_start,
	output logic [TIME_W-1:0]       line_end,
	output logic [SPK_W-1:0]        speaker_count
);

	localparam int SPK_LIMIT = (MAX_SPEAKERS < RAW_IDS) ? MAX_SPEAKERS : RAW_IDS;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_RESOLVE = 3'd2;
	localparam logic [2:0] ST_LINE    = 3'd3;

	logic [2:0]         state_q;
	logic               accept;
	scan_ctl_t          ctl;
	scan_res_t          res;
	logic [GAP_W-1:0]   gap_limit_q;
	logic [RAW_IDS-1:0] map_valid_q;
	logic [RAW_W-1:0]   map_mem_q [RAW_IDS];
	logic [RAW_W-1:0]   map_rd_q;
	logic               raw_found_q;
	logic [RAW_W-1:0]   raw_q;
	logic [SPK_W-1:0]   seen_q;
	logic [SPK_W-1:0]   code_q;
	logic               line_open_q;
	logic [SPK_W-1:0]   line_spk_q;
	logic [TIME_W-1:0]  line_begin_q;
	logic [TIME_W-1:0]  word_s_q;
	logic [TIME_W-1:0]  word_e_q;
	logic               done_q;
	logic               fresh;
	logic               map_new;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	always_comb begin
		ctl = '0;
		if (accept) begin
			unique case (req_type)
				REQ_CLEAR: ctl.clear = 1'b1;
				REQ_LOAD:  ctl.load  = 1'b1;
				REQ_ATTR:  ctl.scan  = 1'b1;
				default:   ctl       = '0;
			endcase
		end
	end

	isa_turn_scan #(
		.MAX_TURNS(MAX_TURNS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.time_start (time_start),
		.time_end   (time_end),
		.raw_speaker(raw_speaker),
		.gap_limit  (gap_limit_q),
		.res        (res)
	);

	// a raw id seen for the first time gets the next dense number if room is left
	assign map_new = raw_found_q && !map_valid_q[raw_q] && (seen_q < SPK_W'(SPK_LIMIT));
	assign fresh   = !(line_open_q && (line_spk_q == code_q));

	always_ff @(posedge clk) begin
		map_rd_q <= map_mem_q[res.raw];
		if ((state_q == ST_RESOLVE) && map_new) begin
			map_mem_q[raw_q] <= seen_q[RAW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gap_limit_q <= GAP_RESET;
			map_valid_q <= '0;
			seen_q      <= '0;
			line_open_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				gap_limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.clear) begin
						map_valid_q <= '0;
						seen_q      <= '0;
						line_open_q <= 1'b0;
					end else if (ctl.scan) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (res.done) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (map_new) begin
						map_valid_q[raw_q] <= 1'b1;
						seen_q             <= seen_q + 1'b1;
					end
					state_q <= ST_LINE;
				end
				ST_LINE: begin
					line_open_q <= 1'b1;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			word_s_q <= time_start;
			word_e_q <= time_end;
		end
		if ((state_q == ST_SCAN) && res.done) begin
			raw_found_q <= res.found;
			raw_q       <= res.raw;
		end
		if (state_q == ST_RESOLVE) begin
			if (!raw_found_q) begin
				code_q <= UNKNOWN_CODE;
			end else if (map_valid_q[raw_q]) begin
				code_q <= {1'b0, map_rd_q};
			end else if (map_new) begin
				code_q <= seen_q;
			end else begin
				code_q <= UNKNOWN_CODE;
			end
		end
		if (state_q == ST_LINE) begin
			if (fresh) begin
				line_spk_q   <= code_q;
				line_begin_q <= word_s_q;
			end
			speaker       <= $signed(code_q);
			new_line      <= fresh;
			line_start    <= fresh ? word_s_q : line_begin_q;
			line_end      <= word_e_q;
			speaker_count <= seen_q;
		end
	end

	assign done = done_q;

	`ISA_ASSERT_NEXT(a_line_strobes, clk, arst_n, state_q == ST_LINE, done_q && !busy)
	`ISA_ASSERT_IMPLIES(a_seen_bound, clk, arst_n, 1'b1, seen_q <= SPK_W'(SPK_LIMIT))
	`ISA_ASSERT_NEXT(a_attr_busy, clk, arst_n, accept && (req_type == REQ_ATTR), busy)

endmodule

FILE: sv/isa_turn_scan.sv
// ----------------------------------------------------------------------------
// isa_turn_scan
// turn table memory and the overlap / nearest-gap scan over loaded turns
// ----------------------------------------------------------------------------
`include "interval_speaker_attribution_assert.svh"

module isa_turn_scan
	import isa_pkg::*;
#(
	parameter int MAX_TURNS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  logic [TIME_W-1:0] time_start,
	input  logic [TIME_W-1:0] time_end,
	input  logic [RAW_W-1:0]  raw_speaker,
	input  logic [GAP_W-1:0]  gap_limit,
	output scan_res_t         res
);

	localparam int CNT_W = $clog2(MAX_TURNS + 1);
	localparam int IDX_W = (MAX_TURNS > 1) ? $clog2(MAX_TURNS) : 1;

	turn_t turn_mem_q [MAX_TURNS];

	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  issue_cnt_q;
	logic              active_q;
	logic              issue;
	logic              rd_vld_s1;
	logic              vld_s2;
	logic              tail_s1;
	logic              tail_s2;
	turn_t             rd_data_s1;
	logic [TIME_W-1:0] word_s_q;
	logic [TIME_W-1:0] word_e_q;

	logic signed [DIFF_W-1:0] ovl_s2;
	logic signed [DIFF_W-1:0] gap_s2;
	logic [RAW_W-1:0]         owner_s2;
	logic signed [DIFF_W-1:0] best_ovl_q;
	logic signed [DIFF_W-1:0] near_gap_q;
	logic                     best_found_q;
	logic                     near_found_q;
	logic [RAW_W-1:0]         best_owner_q;
	logic [RAW_W-1:0]         near_owner_q;

	logic [TIME_W-1:0]        lo;
	logic [TIME_W-1:0]        hi;
	logic signed [DIFF_W-1:0] g1;
	logic signed [DIFF_W-1:0] g2;

	assign issue = active_q && (issue_cnt_q < loaded_q);

	// turn memory: one write port for loads, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (ctl.load && (loaded_q < CNT_W'(MAX_TURNS))) begin
			turn_mem_q[loaded_q[IDX_W-1:0]] <= '{ts: time_start, te: time_end, owner: raw_speaker};
		end
		rd_data_s1 <= turn_mem_q[issue_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			issue_cnt_q <= '0;
			active_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
			tail_s1     <= 1'b0;
			tail_s2     <= 1'b0;
		end else begin
			if (ctl.clear) begin
				loaded_q <= '0;
			end else if (ctl.load && (loaded_q < CNT_W'(MAX_TURNS))) begin
				loaded_q <= loaded_q + 1'b1;
			end
			if (ctl.scan) begin
				issue_cnt_q <= '0;
				active_q    <= 1'b1;
			end else if (issue) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end else begin
				active_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			vld_s2    <= rd_vld_s1;
			// end marker trails the last read through the pipe
			tail_s1   <= active_q && !issue && !ctl.scan;
			tail_s2   <= tail_s1;
		end
	end

	// overlap and gap of the turn just read
	always_comb begin
		lo = (word_s_q > rd_data_s1.ts) ? word_s_q : rd_data_s1.ts;
		hi = (word_e_q < rd_data_s1.te) ? word_e_q : rd_data_s1.te;
		g1 = $signed({1'b0, rd_data_s1.ts}) - $signed({1'b0, word_e_q});
		g2 = $signed({1'b0, word_s_q}) - $signed({1'b0, rd_data_s1.te});
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			word_s_q     <= time_start;
			word_e_q     <= time_end;
			best_ovl_q   <= '0;
			near_gap_q   <= $signed({{(DIFF_W - GAP_W){1'b0}}, gap_limit});
			best_found_q <= 1'b0;
			near_found_q <= 1'b0;
		end else if (vld_s2) begin
			// strict compares keep the first turn on ties
			if (ovl_s2 > best_ovl_q) begin
				best_ovl_q   <= ovl_s2;
				best_owner_q <= owner_s2;
				best_found_q <= 1'b1;
			end
			if ((ovl_s2 <= 0) && (gap_s2 < near_gap_q)) begin
				near_gap_q   <= gap_s2;
				near_owner_q <= owner_s2;
				near_found_q <= 1'b1;
			end
		end
		ovl_s2   <= $signed({1'b0, hi}) - $signed({1'b0, lo});
		gap_s2   <= (g1 > g2) ? g1 : g2;
		owner_s2 <= rd_data_s1.owner;
	end

	assign res.done  = tail_s2;
	assign res.found = best_found_q || near_found_q;
	assign res.raw   = best_found_q ? best_owner_q : near_owner_q;

	`ISA_ASSERT_IMPLIES(a_loaded_bound, clk, arst_n, 1'b1, loaded_q <= CNT_W'(MAX_TURNS))
	`ISA_ASSERT_IMPLIES(a_done_drained, clk, arst_n, res.done, !active_q && !rd_vld_s1 && !vld_s2)
	`ISA_ASSERT_NEXT(a_scan_starts, clk, arst_n, ctl.scan, active_q && (issue_cnt_q == '0))

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for interval_speaker_attribution: a short table of
// directed requests, random sessions of clear, load and attribute requests
// under several gap limits and a full turn table with every raw speaker id;
// word results are compared with a row's typed values or a predictor in the bench
// ----------------------------------------------------------------------------
module tb_top;
	import isa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TURN_SLOTS    = 256;
	localparam int SPEAKER_SLOTS = 64;
	localparam int ITEM_GOAL     = 1650;
	localparam int QUIET_AFTER   = 1450;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct packed {
		logic [SPK_W-1:0]  spk_code;
		logic              opens;
		logic [TIME_W-1:0] ln_start;
		logic [TIME_W-1:0] ln_end;
		logic [SPK_W-1:0]  spk_count;
	} line_res_t;

	typedef struct packed {
		logic [1:0]        req;
		logic [TIME_W-1:0] ws;
		logic [TIME_W-1:0] we;
		logic [RAW_W-1:0]  raw;
		logic              typed;
		line_res_t         want;
	} row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [1:0]              req_type = REQ_CLEAR;
	logic [TIME_W-1:0]       time_start = '0;
	logic [TIME_W-1:0]       time_end = '0;
	logic [RAW_W-1:0]        raw_speaker = '0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [GAP_W-1:0]        cfg_data = '0;
	logic                    done;
	logic signed [SPK_W-1:0] speaker;
	logic                    new_line;
	logic [TIME_W-1:0]       line_start;
	logic [TIME_W-1:0]       line_end;
	logic [SPK_W-1:0]        speaker_count;

	// predictor state
	logic [TIME_W-1:0] turn_lo [TURN_SLOTS];
	logic [TIME_W-1:0] turn_hi [TURN_SLOTS];
	logic [RAW_W-1:0]  turn_raw [TURN_SLOTS];
	int                n_turns;
	bit                raw_known [RAW_IDS];
	int                raw_dense [RAW_IDS];
	int                n_speakers;
	bit                line_live;
	logic [SPK_W-1:0]  line_spk;
	logic [TIME_W-1:0] line_from;
	logic [TIME_W-1:0] line_to;
	logic [GAP_W-1:0]  gap_limit;

	line_res_t pending_lines [$];
	row_t      directed_rows [22];
	int        mismatches = 0;
	int        items_sent = 0;
	int        cycle_count = 0;
	bit        idle_on = 1'b1;

	interval_speaker_attribution #(
		.MAX_TURNS    (TURN_SLOTS),
		.MAX_SPEAKERS (SPEAKER_SLOTS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.time_start    (time_start),
		.time_end      (time_end),
		.raw_speaker   (raw_speaker),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.speaker       (speaker),
		.new_line      (new_line),
		.line_start    (line_start),
		.line_end      (line_end),
		.speaker_count (speaker_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void wipe_tables();
		n_turns = 0;
		n_speakers = 0;
		line_live = 1'b0;
		line_spk = '0;
		line_from = '0;
		line_to = '0;
		foreach (raw_known[i]) raw_known[i] = 1'b0;
	endfunction

	// updates the predictor for one accepted request, returns 1 when a line result is due
	function automatic bit apply_request(input logic [1:0] req, input logic [TIME_W-1:0] ws,
			input logic [TIME_W-1:0] we, input logic [RAW_W-1:0] raw, output line_res_t res);
		longint s64, e64, ts, te, lo, hi, ov, gap, pick_ov, fb_gap;
		int pick, fb, raw_pick, dense;
		logic [SPK_W-1:0] code;
		bit opens;
		res = '0;
		case (req)
			REQ_CLEAR: begin
				wipe_tables();
				return 1'b0;
			end
			REQ_LOAD: begin
				if (n_turns < TURN_SLOTS) begin
					turn_lo[n_turns] = ws;
					turn_hi[n_turns] = we;
					turn_raw[n_turns] = raw;
					n_turns++;
				end
				return 1'b0;
			end
			REQ_ATTR: begin
				s64 = ws;
				e64 = we;
				pick = -1;
				pick_ov = 0;
				fb = -1;
				fb_gap = gap_limit;
				for (int i = 0; i < n_turns; i++) begin
					ts = turn_lo[i];
					te = turn_hi[i];
					lo = (s64 > ts) ? s64 : ts;
					hi = (e64 < te) ? e64 : te;
					ov = hi - lo;
					gap = (ts - e64 > s64 - te) ? ts - e64 : s64 - te;
					// strict compares keep the first turn on ties
					if (ov > pick_ov) begin
						pick_ov = ov;
						pick = turn_raw[i];
					end
					if (ov <= 0 && gap < fb_gap) begin
						fb_gap = gap;
						fb = turn_raw[i];
					end
				end
				raw_pick = (pick >= 0) ? pick : fb;
				dense = -1;
				if (raw_pick >= 0) begin
					if (raw_known[raw_pick]) begin
						dense = raw_dense[raw_pick];
					end else if (n_speakers < SPEAKER_SLOTS) begin
						raw_known[raw_pick] = 1'b1;
						raw_dense[raw_pick] = n_speakers;
						dense = n_speakers;
						n_speakers++;
					end
				end
				code = (dense < 0) ? UNKNOWN_CODE : SPK_W'(dense);
				opens = !(line_live && line_spk == code);
				if (opens) begin
					line_live = 1'b1;
					line_spk = code;
					line_from = ws;
				end
				line_to = we;
				res = '{code, opens, line_from, line_to, SPK_W'(n_speakers)};
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_request(input logic [1:0] req, input logic [TIME_W-1:0] ws,
			input logic [TIME_W-1:0] we, input logic [RAW_W-1:0] raw,
			input bit typed = 1'b0, input line_res_t want = '0);
		line_res_t fresh_res;
		start <= 1'b1;
		req_type <= req;
		time_start <= ws;
		time_end <= we;
		raw_speaker <= raw;
		do @(posedge clk); while (busy);
		if (apply_request(req, ws, we, raw, fresh_res))
			pending_lines = {pending_lines, typed ? want : fresh_res};
		if (req != REQ_SPARE)
			items_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// hold requests back until every line result is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_gap_limit(input logic [GAP_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gap_limit = v;
	endtask

	// full turn table, every raw id met, loads past capacity must be dropped
	task automatic fill_table();
		int k;
		send_request(REQ_CLEAR, $urandom, $urandom, RAW_W'($urandom));
		for (int i = 0; i < TURN_SLOTS + 4; i++) begin
			if (i < TURN_SLOTS)
				send_request(REQ_LOAD, 100 * i, 100 * i + 60, RAW_W'(i));
			else
				send_request(REQ_LOAD, 32'd0, 32'hFFFF_FFFF, RAW_W'(i));
		end
		for (int j = 0; j < RAW_IDS + 10; j++) begin
			k = (j < RAW_IDS) ? (j * 37) % RAW_IDS : $urandom_range(RAW_IDS, TURN_SLOTS - 1);
			send_request(REQ_ATTR, 100 * k + 10, 100 * k + 90, RAW_W'($urandom));
		end
		send_request(REQ_ATTR, 100 * TURN_SLOTS + 400, 100 * TURN_SLOTS + 700, '0);
	endtask

	task automatic play_session();
		int n_load, n_word, pool;
		logic [TIME_W-1:0] base, cursor, span, ws, we;
		if ($urandom_range(0, 4) != 0)
			send_request(REQ_CLEAR, $urandom, $urandom, RAW_W'($urandom));
		base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000);
		pool = $urandom_range(0, 1) ? 7 : RAW_IDS - 1;
		n_load = $urandom_range(0, 12);
		if ($urandom_range(0, 15) == 0)
			n_load = $urandom_range(20, 60);
		cursor = base;
		for (int i = 0; i < n_load; i++) begin
			ws = cursor + $urandom_range(0, 600);
			we = ws + $urandom_range(0, 3000);
			if ($urandom_range(0, 15) == 0)
				{ws, we} = {we, ws};
			send_request(REQ_LOAD, ws, we, RAW_W'($urandom_range(0, pool)));
			cursor = cursor + $urandom_range(0, 2500);
		end
		span = cursor - base + 3000;
		n_word = $urandom_range(1, 12);
		for (int i = 0; i < n_word; i++) begin
			ws = base - 32'd2500 + $urandom_range(0, span + 5000);
			we = ws + $urandom_range(0, 1500);
			case ($urandom_range(0, 11))
				0: we = ws;
				1: {ws, we} = {we, ws};
				default: ;
			endcase
			send_request(REQ_ATTR, ws, we, RAW_W'($urandom));
			case ($urandom_range(0, 9))
				0: send_request(2'($urandom_range(0, 3)), $urandom, $urandom, RAW_W'($urandom));
				1: send_request(REQ_LOAD, base + $urandom_range(0, span), cursor,
					RAW_W'($urandom_range(0, pool)));
				default: ;
			endcase
		end
	endtask

	// line results, one strobe per result, cannot be held off; the block takes no new request while busy
	function automatic void check_field(input string what, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		line_res_t ref_res;
		if (arst_n && done) begin
			if (pending_lines.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got speaker %0d",
					$time, speaker);
			end else begin
				ref_res = pending_lines.pop_front();
				check_field("speaker", ref_res.spk_code, $unsigned(speaker));
				check_field("new_line", ref_res.opens, new_line);
				check_field("line_start", ref_res.ln_start, line_start);
				check_field("line_end", ref_res.ln_end, line_end);
				check_field("speaker_count", ref_res.spk_count, speaker_count);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		directed_rows = '{
			// empty table after reset: unknown, then the unknown line continues
			'{REQ_ATTR, 32'd100, 32'd200, 6'd0, 1'b1, '{UNKNOWN_CODE, 1'b1, 32'd100, 32'd200, 7'd0}},
			'{REQ_ATTR, 32'd300, 32'd400, 6'd9, 1'b1, '{UNKNOWN_CODE, 1'b0, 32'd100, 32'd400, 7'd0}},
			'{REQ_SPARE, 32'd5, 32'd6, 6'd7, 1'b0, '0},
			'{REQ_LOAD, 32'd0, 32'd1000, 6'd63, 1'b0, '0},
			'{REQ_LOAD, 32'd1000, 32'd2000, 6'd0, 1'b0, '0},
			'{REQ_ATTR, 32'd500, 32'd600, 6'd0, 1'b1, '{7'd0, 1'b1, 32'd500, 32'd600, 7'd1}},
			// equal overlap with both turns
			'{REQ_ATTR, 32'd900, 32'd1100, 6'd0, 1'b0, '0},
			// zero length word inside a turn
			'{REQ_ATTR, 32'd1500, 32'd1500, 6'd0, 1'b0, '0},
			// start after end
			'{REQ_ATTR, 32'd1800, 32'd1200, 6'd0, 1'b0, '0},
			// gap just under and exactly at the limit
			'{REQ_ATTR, 32'd2999, 32'd3500, 6'd0, 1'b0, '0},
			'{REQ_ATTR, 32'd3000, 32'd3100, 6'd0, 1'b0, '0},
			'{REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd42, 1'b0, '0},
			'{REQ_LOAD, 32'd0, 32'hFFFF_FFFF, 6'd21, 1'b0, '0},
			'{REQ_ATTR, 32'd0, 32'hFFFF_FFFF, 6'd63, 1'b0, '0},
			'{REQ_ATTR, 32'hFFFF_FFFF, 32'd0, 6'd63, 1'b0, '0},
			'{REQ_ATTR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1'b0, '0},
			'{REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b0, '0},
			'{REQ_ATTR, 32'd0, 32'd0, 6'd0, 1'b1, '{UNKNOWN_CODE, 1'b1, 32'd0, 32'd0, 7'd0}},
			'{REQ_LOAD, 32'd10, 32'd20, 6'd5, 1'b0, '0},
			'{REQ_ATTR, 32'd10, 32'd20, 6'd0, 1'b1, '{7'd0, 1'b1, 32'd10, 32'd20, 7'd1}},
			'{REQ_ATTR, 32'd10, 32'd20, 6'd0, 1'b1, '{7'd0, 1'b0, 32'd10, 32'd20, 7'd1}},
			'{REQ_ATTR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 1'b1,
				'{UNKNOWN_CODE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1}}
		};
		wipe_tables();
		gap_limit = GAP_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].ws, directed_rows[i].we,
				directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].want);

		set_gap_limit('0);
		repeat (6) play_session();
		set_gap_limit('1);
		repeat (6) play_session();
		set_gap_limit(GAP_RESET);
		fill_table();

		for (int n = 0; items_sent < ITEM_GOAL; n++) begin
			if (n % 12 == 11) begin
				case ($urandom_range(0, 3))
					0: set_gap_limit(16'd1);
					1: set_gap_limit(GAP_W'($urandom));
					2: set_gap_limit(GAP_W'($urandom_range(0, 4000)));
					default: set_gap_limit(GAP_RESET);
				endcase
			end else if ($urandom_range(0, 9) == 0) begin
				drain();
			end
			idle_on = (items_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
			play_session();
		end

		start <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: interval_speaker_attribution.f
+incdir+sv
sv/isa_pkg.sv
sv/isa_turn_scan.sv
sv/interval_speaker_attribution.sv
bench/tb_top.sv
